### hw/rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the pre-trigger capture ring
// Function and status codes, register indexes, reset values and the status
// group that the copy engine reports to the control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int unsigned RingDepthDefault = 16384;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ProbW   = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned IndexW  = 14;
  localparam int unsigned CountW  = 15;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CountW-1:0]    RingLengthRst  = 15'd16384;
  localparam logic [ProbW-1:0]     CutoffRst      = 8'd0;
  localparam logic [IntervalW-1:0] MinIntervalRst = 16'd2000;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_DETECT  = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RELEASE = 2'd3
  } cpr_func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK            = 3'd0,
    STAT_NOT_TRIGGERED = 3'd1,
    STAT_RATE_LIMITED  = 3'd2,
    STAT_BUSY          = 3'd3,
    STAT_EMPTY         = 3'd4,
    STAT_RANGE         = 3'd5
  } cpr_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RING_LENGTH  = 2'd0,
    REG_NEAR_MISS    = 2'd1,
    REG_MIN_INTERVAL = 2'd2,
    REG_UNUSED       = 2'd3
  } cpr_reg_e;

  // Status of the copy engine toward the control logic.
  typedef struct packed {
    logic rd_en;  // ring read issued this cycle
    logic done;   // last snapshot write happens this cycle
  } cpr_copy_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pretrigger_capture_ring.sv
// ----------------------------------------------------------------------------
// pretrigger_capture_ring: pre-trigger audio capture store
// Circular sample store with a snapshot copy taken on detection events.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel with the function code in tuser;
// one result per item leaves on m_axis with the status in tuser.
// A sample write, a release, a refused capture and an out-of-range read are
// answered in the cycle after acceptance, and the next item can be taken
// then, so these run at one item per cycle while each result is taken.
// A valid snapshot read passes the registered snapshot RAM read first.
// An accepted capture copies the ring into the snapshot RAM, one ring read
// per cycle, each sample written in the next cycle; no item is accepted
// during the copy, while its result already waits.
// Reset clears the pointer, wrapped flag, capture time, busy mark and held
// count, sets the registers to reset values; RAM contents stay as they are.
// When the receiver stalls, the single output register holds its result
// and the input side stops taking items until that result is taken.
// Configuration writes are taken at any cycle but are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module pretrigger_capture_ring
  import cpr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // sample[15:0], detected[16], avg_prob[24:17], now_ms[56:25],
  // read_index[70:57], zero[71]
  input  wire logic [71:0]         s_axis_tdata,
  // func[1:0]
  input  wire logic [FuncW-1:0]    s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // snapshot_count[14:0], read_sample[30:15], zero[31]
  output logic      [31:0]         m_axis_tdata,
  // status[2:0]
  output logic      [StatusW-1:0]  m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned LW = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_COPY = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]    ring_len_q, ring_len_d;
  logic [ProbW-1:0]     cutoff_q, cutoff_d;
  logic [IntervalW-1:0] min_int_q, min_int_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic                 wrapped_q, wrapped_d;
  logic [TimeW-1:0]     last_q, last_d;
  logic                 busy_q, busy_d;
  logic [CountW-1:0]    held_q, held_d;

  logic                 out_valid_q, out_valid_d;
  cpr_status_e          out_status_q, out_status_d;
  logic [CountW-1:0]    out_count_q, out_count_d;
  logic [SampleW-1:0]   out_sample_q, out_sample_d;

  logic                 in_acc;
  cpr_func_e            func;
  logic [SampleW-1:0]   in_sample;
  logic                 in_detected;
  logic [ProbW-1:0]     in_prob;
  logic [TimeW-1:0]     in_now;
  logic [IndexW-1:0]    in_index;
  logic [31:0]          index32;

  logic [31:0]          len32;
  logic [LW-1:0]        eff_len;
  logic [LW-1:0]        wp_ext;
  logic [LW-1:0]        avail;
  logic                 trig;
  logic                 rate_lim;
  logic                 capture_ok;
  logic                 read_ok;
  logic [TimeW-1:0]     elapsed;

  logic                 ring_we;
  logic [AW-1:0]        ring_raddr;
  logic [SampleW-1:0]   ring_rdata;
  logic                 snap_we;
  logic [AW-1:0]        snap_waddr;
  logic [SampleW-1:0]   snap_wdata;
  logic                 snap_re;
  logic [SampleW-1:0]   snap_rdata;
  logic                 copy_start;
  cpr_copy_stat_t       copy_stat;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign func        = cpr_func_e'(s_axis_tuser);
  assign in_sample   = s_axis_tdata[15:0];
  assign in_detected = s_axis_tdata[16];
  assign in_prob     = s_axis_tdata[24:17];
  assign in_now      = s_axis_tdata[56:25];
  assign in_index    = s_axis_tdata[70:57];
  assign index32     = {18'd0, in_index};

  // Active length: zero acts as one, anything above the depth as the depth.
  always_comb begin
    len32 = {17'd0, ring_len_q};
    if (ring_len_q == '0) begin
      len32 = 32'd1;
    end else if (len32 > RING_DEPTH) begin
      len32 = RING_DEPTH;
    end
  end

  assign eff_len = LW'(len32);
  assign wp_ext  = LW'(wp_q);
  assign avail   = wrapped_q ? eff_len : wp_ext;
  assign elapsed = in_now - last_q;

  assign trig     = in_detected || ((cutoff_q != '0) && (in_prob >= cutoff_q));
  assign rate_lim = (last_q != '0) && (elapsed < {16'd0, min_int_q});
  assign capture_ok = trig && !rate_lim && !busy_q && (avail != '0);
  assign read_ok  = ({1'b0, in_index} < held_q) && (index32 < RING_DEPTH);

  assign ring_we    = in_acc && (func == FUNC_WRITE);
  assign copy_start = in_acc && (func == FUNC_DETECT) && capture_ok;
  assign snap_re    = in_acc && (func == FUNC_READ) && read_ok;

  always_comb begin
    state_d      = state_q;
    ring_len_d   = ring_len_q;
    cutoff_d     = cutoff_q;
    min_int_d    = min_int_q;
    wp_d         = wp_q;
    wrapped_d    = wrapped_q;
    last_d       = last_q;
    busy_d       = busy_q;
    held_d       = held_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_sample_d = out_sample_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_count_d  = held_q;
          out_sample_d = '0;
          unique case (func)
            FUNC_WRITE: begin
              if (wp_ext + LW'(1) == eff_len) begin
                wp_d      = '0;
                wrapped_d = 1'b1;
              end else begin
                wp_d = wp_q + AW'(1);
              end
            end
            FUNC_DETECT: begin
              if (!trig) begin
                out_status_d = STAT_NOT_TRIGGERED;
              end else if (rate_lim) begin
                out_status_d = STAT_RATE_LIMITED;
              end else if (busy_q) begin
                out_status_d = STAT_BUSY;
              end else if (avail == '0) begin
                out_status_d = STAT_EMPTY;
              end else begin
                held_d      = CountW'(avail);
                out_count_d = CountW'(avail);
                busy_d      = 1'b1;
                last_d      = in_now;
                state_d     = ST_COPY;
              end
            end
            FUNC_READ: begin
              if (read_ok) begin
                // The result waits for the registered snapshot read.
                out_valid_d = 1'b0;
                state_d     = ST_READ;
              end else begin
                out_status_d = STAT_RANGE;
              end
            end
            FUNC_RELEASE: begin
              busy_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d  = 1'b1;
        out_status_d = STAT_OK;
        out_count_d  = held_q;
        out_sample_d = snap_rdata;
        state_d      = ST_IDLE;
      end
      ST_COPY: begin
        if (copy_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cpr_reg_e'(cfg_idx_i))
        REG_RING_LENGTH: begin
          ring_len_d = cfg_data_i[CountW-1:0];
          wp_d       = '0;
          wrapped_d  = 1'b0;
        end
        REG_NEAR_MISS:    cutoff_d  = cfg_data_i[ProbW-1:0];
        REG_MIN_INTERVAL: min_int_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_len_q  <= RingLengthRst;
      cutoff_q    <= CutoffRst;
      min_int_q   <= MinIntervalRst;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      last_q      <= '0;
      busy_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_len_q  <= ring_len_d;
      cutoff_q    <= cutoff_d;
      min_int_q   <= min_int_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      last_q      <= last_d;
      busy_q      <= busy_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_sample_q <= out_sample_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_sample_q, out_count_q};

  cpr_ram #(
    .WIDTH (SampleW),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (in_sample),
    .re_i    (copy_stat.rd_en),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  cpr_copy #(
    .RING_DEPTH (RING_DEPTH)
  ) u_copy (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (copy_start),
    .start_ptr_i  (wrapped_q ? wp_q : '0),
    .len_i        (avail),
    .ring_len_i   (eff_len),
    .ring_raddr_o (ring_raddr),
    .ring_rdata_i (ring_rdata),
    .snap_we_o    (snap_we),
    .snap_waddr_o (snap_waddr),
    .snap_wdata_o (snap_wdata),
    .stat_o       (copy_stat)
  );

  cpr_ram #(
    .WIDTH (SampleW),
    .DEPTH (RING_DEPTH)
  ) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (snap_we),
    .waddr_i (snap_waddr),
    .wdata_i (snap_wdata),
    .re_i    (snap_re),
    .raddr_i (AW'(index32)),
    .rdata_o (snap_rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/cpr_ram.sv
// ----------------------------------------------------------------------------
// cpr_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cpr_copy.sv
// ----------------------------------------------------------------------------
// cpr_copy: ring to snapshot copy engine
// Walks the ring oldest-first from a start pointer, wrapping at the active
// length, and writes each sample into the snapshot in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_copy
  import cpr_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDefault,
  localparam int unsigned AW = $clog2(RING_DEPTH),
  localparam int unsigned LW = $clog2(RING_DEPTH + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [AW-1:0]      start_ptr_i,
  input  wire logic [LW-1:0]      len_i,
  input  wire logic [LW-1:0]      ring_len_i,
  output logic      [AW-1:0]      ring_raddr_o,
  input  wire logic [SampleW-1:0] ring_rdata_i,
  output logic                    snap_we_o,
  output logic      [AW-1:0]      snap_waddr_o,
  output logic      [SampleW-1:0] snap_wdata_o,
  output cpr_copy_stat_t          stat_o
);

  logic [LW-1:0] rem_q, rem_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          issue_q, issue_d;
  logic          rd_en;

  assign rd_en = (rem_q != '0);

  always_comb begin
    rem_d   = rem_q;
    rp_d    = rp_q;
    wa_d    = wa_q;
    issue_d = rd_en;
    if (start_i) begin
      rem_d = len_i;
      rp_d  = start_ptr_i;
      wa_d  = '0;
    end else begin
      if (rd_en) begin
        rem_d = rem_q - LW'(1);
        if (LW'(rp_q) + LW'(1) == ring_len_i) begin
          rp_d = '0;
        end else begin
          rp_d = rp_q + AW'(1);
        end
      end
      if (issue_q) begin
        wa_d = wa_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      issue_q <= 1'b0;
      rp_q    <= '0;
      wa_q    <= '0;
    end else begin
      rem_q   <= rem_d;
      issue_q <= issue_d;
      rp_q    <= rp_d;
      wa_q    <= wa_d;
    end
  end

  assign ring_raddr_o = rp_q;
  assign snap_we_o    = issue_q;
  assign snap_waddr_o = wa_q;
  assign snap_wdata_o = ring_rdata_i;
  assign stat_o.rd_en = rd_en;
  assign stat_o.done  = issue_q && (rem_q == '0);

endmodule

`default_nettype wire
